// ===== hw/rtl/bbe_pkg.sv =====
`default_nettype none

package bbe_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int VAL_W = FRAC_BITS + 1;
  localparam int PROD_W = 2 * VAL_W;
  localparam int T_W = 18;
  localparam int DEG_W = 4;
  localparam int BIN_W = 13;
  localparam int HW_DEGREE_LIMIT = 15;
  localparam int TAB_N = HW_DEGREE_LIMIT + 1;

  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DEG_W-1:0] DEGREE_RESET = 4'd3;

  // register index, taken from the word address
  localparam logic REG_DEGREE = 1'b0;

  typedef enum logic [1:0] {
    RGN_LOW,
    RGN_MID,
    RGN_HIGH
  } region_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a parameter item
    ST_PT,     // issue t power step
    ST_PU,     // issue (1-t) power step, store t power
    ST_PW,     // store (1-t) power
    ST_RD,     // read both powers for basis i
    ST_M1,     // multiply the two powers
    ST_M2,     // apply binomial factor
    ST_LD,     // saturate and load output register
    ST_OUT     // hold basis item until taken
  } state_t;

  typedef logic [TAB_N-1:0][TAB_N-1:0][BIN_W-1:0] binom_tab_t;

  // pascal triangle, built at elaboration
  function automatic binom_tab_t binom_table();
    binom_tab_t tab;
    tab = '0;
    for (int n = 0; n < TAB_N; n++) begin
      tab[n][0] = BIN_W'(1);
      for (int i = 1; i <= n; i++) begin
        if (i < n) begin
          tab[n][i] = tab[n-1][i-1] + tab[n-1][i];
        end else begin
          tab[n][i] = tab[n-1][i-1];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = binom_table();

endpackage

`default_nettype wire

// ===== hw/rtl/bbe_mul.sv =====
`default_nettype none

// shared unsigned multiplier with registered product
module bbe_mul (
  input  wire logic                        clk,
  input  wire logic [bbe_pkg::VAL_W-1:0]   a,
  input  wire logic [bbe_pkg::VAL_W-1:0]   b,
  output logic      [bbe_pkg::PROD_W-1:0]  p
);

  localparam int PW = bbe_pkg::PROD_W;

  always_ff @(posedge clk) begin
    p <= PW'(a) * PW'(b);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bernstein_basis_eval_unit.sv =====
// bernstein basis evaluator: one param_t item gives n+1 basis items, n = clamped degree
// inside (0, 1.0): power steps (ST_PT, ST_PU, ST_PW) build t^k and (1-t)^k for k = 1..n, then
//   each basis item passes ST_RD, ST_M1, ST_M2, ST_LD, ST_OUT; at or outside the ends only ST_RD, ST_OUT
// a new param_t item is taken only after the last basis item of the previous one is taken; the
//   single shared multiplier does 2 multiplies per power step and 2 multiplies per basis value
// reset: synchronous, active high; degree returns to 3, sequencer idles, no item pending
`default_nettype none

module bernstein_basis_eval_unit #(
  parameter int MAX_DEGREE = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // parameter channel
  input  wire logic                        param_valid,
  output logic                             param_stall,
  input  wire logic signed [bbe_pkg::T_W-1:0] param_t,
  // basis channel
  output logic                             basis_valid,
  input  wire logic                        basis_stall,
  output logic      [bbe_pkg::DEG_W-1:0]   basis_index,
  output logic      [bbe_pkg::VAL_W-1:0]   basis_value,
  output logic                             last_value
);

  // effective degree limit and power table depth
  localparam int NMAX = (MAX_DEGREE < bbe_pkg::HW_DEGREE_LIMIT) ?
                        MAX_DEGREE : bbe_pkg::HW_DEGREE_LIMIT;
  localparam int DEPTH = NMAX + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int VW = bbe_pkg::VAL_W;
  localparam int PW = bbe_pkg::PROD_W;
  localparam int DW = bbe_pkg::DEG_W;
  localparam int FB = bbe_pkg::FRAC_BITS;

  // sequencer
  bbe_pkg::state_t state, state_next;

  logic [DW-1:0]         degree;
  bbe_pkg::region_t      region, region_in;
  logic [VW-1:0]         tv, uv;
  logic [VW-1:0]         tacc, uacc;
  logic [IDX_W-1:0]      k, i;
  logic [IDX_W-1:0]      n;
  logic [DW-1:0]         n_clamp;
  logic [IDX_W-1:0]      up_addr;
  logic                  accept;
  logic                  cfg_write;

  // power tables: t^k and (1-t)^k, truncated after every multiply
  logic [VW-1:0]         tp_mem [DEPTH];
  logic [VW-1:0]         up_mem [DEPTH];
  logic [VW-1:0]         tp_rd, up_rd;
  logic                  tp_we, up_we;
  logic [IDX_W-1:0]      tp_wa, up_wa;
  logic [VW-1:0]         tp_wd, up_wd;

  // shared multiplier
  logic [VW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         mul_p;
  logic [VW-1:0]         mul_frac;
  logic [VW-1:0]         sat_val;
  logic [VW-1:0]         edge_val;
  logic [bbe_pkg::BIN_W-1:0] binom;

  // config: one register, word index from paddr[2]
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= bbe_pkg::DEGREE_RESET;
    end else if (cfg_write && (paddr[2] == bbe_pkg::REG_DEGREE)) begin
      degree <= pwdata[DW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bbe_pkg::REG_DEGREE) begin
      prdata = {{(32-DW){1'b0}}, degree};
    end
  end

  // clamp degree to what the tables hold
  assign n_clamp = (degree > DW'(NMAX)) ? DW'(NMAX) : degree;
  assign n = n_clamp[IDX_W-1:0];

  // input handshake: one item at a time, nothing taken during reset
  assign param_stall = rst || (state != bbe_pkg::ST_IDLE);
  assign accept = param_valid && !param_stall;

  // classify t: at or below zero, at or above 1.0, or inside
  always_comb begin
    if (param_t[bbe_pkg::T_W-1] || (param_t == '0)) begin
      region_in = bbe_pkg::RGN_LOW;
    end else if (param_t[FB]) begin
      region_in = bbe_pkg::RGN_HIGH;
    end else begin
      region_in = bbe_pkg::RGN_MID;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbe_pkg::ST_IDLE: begin
        if (accept) begin
          if ((region_in == bbe_pkg::RGN_MID) && (n != '0)) begin
            state_next = bbe_pkg::ST_PT;
          end else begin
            state_next = bbe_pkg::ST_RD;
          end
        end
      end
      bbe_pkg::ST_PT: state_next = bbe_pkg::ST_PU;
      bbe_pkg::ST_PU: state_next = bbe_pkg::ST_PW;
      bbe_pkg::ST_PW: begin
        if (k == n) begin
          state_next = bbe_pkg::ST_RD;
        end else begin
          state_next = bbe_pkg::ST_PT;
        end
      end
      bbe_pkg::ST_RD: begin
        if (region == bbe_pkg::RGN_MID) begin
          state_next = bbe_pkg::ST_M1;
        end else begin
          state_next = bbe_pkg::ST_OUT;
        end
      end
      bbe_pkg::ST_M1: state_next = bbe_pkg::ST_M2;
      bbe_pkg::ST_M2: state_next = bbe_pkg::ST_LD;
      bbe_pkg::ST_LD: state_next = bbe_pkg::ST_OUT;
      bbe_pkg::ST_OUT: begin
        if (!basis_stall) begin
          if (i == n) begin
            state_next = bbe_pkg::ST_IDLE;
          end else begin
            state_next = bbe_pkg::ST_RD;
          end
        end
      end
      default: state_next = bbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbe_pkg::ST_IDLE;
      basis_valid <= 1'b0;
    end else begin
      state <= state_next;
      basis_valid <= (state_next == bbe_pkg::ST_OUT);
    end
  end

  // multiplier operand select
  assign mul_frac = mul_p[FB +: VW];
  assign binom = bbe_pkg::BINOM_TAB[4'(n)][4'(i)];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      bbe_pkg::ST_PT: begin
        mul_a = tacc;
        mul_b = tv;
      end
      bbe_pkg::ST_PU: begin
        mul_a = uacc;
        mul_b = uv;
      end
      bbe_pkg::ST_M1: begin
        mul_a = tp_rd;
        mul_b = up_rd;
      end
      bbe_pkg::ST_M2: begin
        mul_a = VW'(binom);
        mul_b = mul_frac;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // power table writes: entry 0 is 1.0, entry k comes from the multiplier
  assign tp_we = accept || (state == bbe_pkg::ST_PU);
  assign tp_wa = (state == bbe_pkg::ST_IDLE) ? '0 : k;
  assign tp_wd = (state == bbe_pkg::ST_IDLE) ? bbe_pkg::ONE : mul_frac;
  assign up_we = accept || (state == bbe_pkg::ST_PW);
  assign up_wa = (state == bbe_pkg::ST_IDLE) ? '0 : k;
  assign up_wd = (state == bbe_pkg::ST_IDLE) ? bbe_pkg::ONE : mul_frac;

  assign up_addr = n - i;

  always_ff @(posedge clk) begin
    if (tp_we) begin
      tp_mem[tp_wa] <= tp_wd;
    end
    if (up_we) begin
      up_mem[up_wa] <= up_wd;
    end
    tp_rd <= tp_mem[i];
    up_rd <= up_mem[up_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      region <= region_in;
      tv     <= {1'b0, param_t[FB-1:0]};
      uv     <= bbe_pkg::ONE - {1'b0, param_t[FB-1:0]};
      tacc   <= bbe_pkg::ONE;
      uacc   <= bbe_pkg::ONE;
      k      <= IDX_W'(1);
      i      <= '0;
    end else begin
      case (state)
        bbe_pkg::ST_PU: tacc <= mul_frac;
        bbe_pkg::ST_PW: begin
          uacc <= mul_frac;
          if (k != n) begin
            k <= k + IDX_W'(1);
          end
        end
        bbe_pkg::ST_OUT: begin
          if (!basis_stall && (i != n)) begin
            i <= i + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // binomial product saturates at 1.0
  assign sat_val = (mul_p > PW'(bbe_pkg::ONE)) ? bbe_pkg::ONE : mul_p[VW-1:0];

  // ends of the interval: a single 1.0 at the first or the last index
  always_comb begin
    edge_val = '0;
    if ((region == bbe_pkg::RGN_LOW) && (i == '0)) begin
      edge_val = bbe_pkg::ONE;
    end else if ((region == bbe_pkg::RGN_HIGH) && (i == n)) begin
      edge_val = bbe_pkg::ONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (((state == bbe_pkg::ST_RD) && (region != bbe_pkg::RGN_MID)) ||
        (state == bbe_pkg::ST_LD)) begin
      basis_index <= DW'(i);
      last_value  <= (i == n);
      basis_value <= (state == bbe_pkg::ST_LD) ? sat_val : edge_val;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbe_checker.sv =====
`default_nettype none

module bbe_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       param_valid,
  input wire logic                       param_stall,
  input wire logic                       basis_valid,
  input wire logic                       basis_stall,
  input wire logic [bbe_pkg::DEG_W-1:0]  basis_index,
  input wire logic [bbe_pkg::VAL_W-1:0]  basis_value,
  input wire logic                       last_value
);

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !basis_valid)
    else $error("basis item valid after reset");

  // an accepted parameter item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (param_valid && !param_stall) |=> param_stall)
    else $error("block ready right after accepting an item");

  // no new parameter item while a basis item waits
  a_stall_while_out: assert property (@(posedge clk) disable iff (rst)
    basis_valid |-> param_stall)
    else $error("input ready while basis item pending");

  // basis values never exceed 1.0
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    basis_valid |-> (basis_value <= bbe_pkg::ONE))
    else $error("basis value above 1.0");

  // stalled basis item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (basis_valid && basis_stall) |=>
      (basis_valid && $stable(basis_value) && $stable(basis_index) && $stable(last_value)))
    else $error("stalled basis item changed");

endmodule

bind bernstein_basis_eval_unit bbe_checker u_bbe_checker (
  .clk         (clk),
  .rst         (rst),
  .param_valid (param_valid),
  .param_stall (param_stall),
  .basis_valid (basis_valid),
  .basis_stall (basis_stall),
  .basis_index (basis_index),
  .basis_value (basis_value),
  .last_value  (last_value)
);

`default_nettype wire
